// ===== rtl/core/btip_pkg.sv =====
// ----------------------------------------------------------------------------
// btip_pkg: shared types and constants of the bitplane pixel decoder
// Holds the size defaults, config register indexes and the front/back job
// record.
// ----------------------------------------------------------------------------
package btip_pkg;

  localparam int MaxWidthDef     = 1024;
  localparam int MaxPlanesDef    = 8;
  localparam int PaletteDepthDef = 256;
  localparam int MaxHeight       = 1024;
  localparam int WordBits        = 16;
  localparam int LastBit         = 15;

  // config register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BPP    = 3'd2;
  localparam logic [2:0] REG_COLORS = 3'd3;
  localparam logic [2:0] REG_PLANAR = 3'd4;

  // input item kinds
  localparam logic FUNC_WORD  = 1'b0;
  localparam logic FUNC_ENTRY = 1'b1;

  // one group job handed from front to back
  typedef struct packed {
    logic [15:0] word;     // last plane word of the group
    logic [3:0]  planes;   // effective plane count
    logic [11:0] base;     // row store address of plane 0 of this group
    logic [11:0] stride;   // address step between planes
    logic        valid;    // plane layout allows a real index
    logic [8:0]  colors;   // effective color count
    logic [11:0] x0;       // column of first pixel
    logic [4:0]  npix;     // pixels to emit, 1..16
    logic [9:0]  y;
    logic        fdone;    // this group ends the frame
  } job_t;

endpackage

// ===== rtl/core/btip_ram.sv =====
// ----------------------------------------------------------------------------
// btip_ram: generic single port write, single port read memory
// Registered read data.
// ----------------------------------------------------------------------------
module btip_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/btip_front.sv =====
// ----------------------------------------------------------------------------
// btip_front: item intake, config registers and frame counters
// Stores early plane words, writes the palette and queues one job per group.
// ----------------------------------------------------------------------------
module btip_front #(
  parameter int MAX_WIDTH     = btip_pkg::MaxWidthDef,
  parameter int MAX_PLANES    = btip_pkg::MaxPlanesDef,
  parameter int PALETTE_DEPTH = btip_pkg::PaletteDepthDef,
  localparam int RS_DEPTH     = (MAX_PLANES - 1) * ((MAX_WIDTH + 15) / 16) + 1,
  localparam int RS_AW        = (RS_DEPTH > 1) ? $clog2(RS_DEPTH) : 1,
  localparam int PAL_AW       = $clog2(PALETTE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [10:0]         cfg_data,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_func,
  input  logic [15:0]         in_plane_word,
  input  logic [7:0]          in_entry_index,
  input  logic [31:0]         in_entry_color,
  output logic                rs_we,
  output logic [RS_AW-1:0]    rs_waddr,
  output logic [15:0]         rs_wdata,
  output logic                pal_we,
  output logic [PAL_AW-1:0]   pal_waddr,
  output logic [31:0]         pal_wdata,
  output logic                job_push,
  output btip_pkg::job_t      job,
  input  logic                job_full,
  input  logic                rs_busy,
  input  logic                pal_busy
);
  import btip_pkg::*;

  logic [10:0] width_r, height_r;
  logic [3:0]  bpp_r;
  logic [8:0]  colors_r;
  logic        planar_r;
  logic [3:0]  plane_r, plane_nxt;
  logic [8:0]  group_r, group_nxt;
  logic [10:0] row_r, row_nxt;

  logic [12:0] eff_w;
  logic [10:0] eff_h;
  logic [3:0]  eff_p;
  logic [8:0]  ngroups;
  logic [9:0]  pow_p;
  logic [8:0]  eff_c;
  logic        ilv_ok;
  logic [3:0]  p_cur;
  logic [8:0]  g_cur;
  logic [10:0] r_cur;
  logic        accept, is_last, emit;
  logic [12:0] x0_full, rem;

  // effective settings
  always_comb begin
    eff_w = (width_r == 11'd0) ? 13'd1 :
            ({2'd0, width_r} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {2'd0, width_r};
    eff_h = (height_r == 11'd0) ? 11'd1 :
            (height_r > 11'(MaxHeight)) ? 11'(MaxHeight) : height_r;
    eff_p = (bpp_r == 4'd0) ? 4'd1 :
            (bpp_r > 4'(MAX_PLANES)) ? 4'(MAX_PLANES) : bpp_r;
    ngroups = 9'((eff_w + 13'd15) >> 4);
    pow_p   = 10'd1 << eff_p;
    if (colors_r != 9'd0) begin
      eff_c = (colors_r > 9'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH) : colors_r;
    end else begin
      eff_c = (pow_p > 10'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH) : pow_p[8:0];
    end
    ilv_ok = ((bpp_r == 4'd1) || (bpp_r == 4'd2) || (bpp_r == 4'd4) ||
              (bpp_r == 4'd8)) && (bpp_r <= 4'(MAX_PLANES));
  end

  // intake stall: stored words wait for pending gathers, palette writes for an idle back
  always_comb begin
    if (in_func == FUNC_ENTRY) begin
      in_full = pal_busy;
    end else if (is_last) begin
      in_full = job_full;
    end else begin
      in_full = rs_busy;
    end
  end

  // counter wrap on use
  always_comb begin
    p_cur = (plane_r >= eff_p) ? 4'd0 : plane_r;
    g_cur = (group_r >= ngroups) ? 9'd0 : group_r;
    r_cur = (row_r >= eff_h) ? 11'd0 : row_r;
    is_last = (p_cur + 4'd1 == eff_p);
    accept  = in_push && !in_full;
    x0_full = {g_cur, 4'd0};
    rem     = eff_w - x0_full;
    emit    = accept && (in_func == FUNC_WORD) && is_last;
  end

  // row store, palette and job outputs
  always_comb begin
    rs_we    = accept && (in_func == FUNC_WORD) && !is_last;
    rs_waddr = planar_r ? RS_AW'(p_cur * ngroups + g_cur) : RS_AW'(p_cur);
    rs_wdata = in_plane_word;
    pal_we    = accept && (in_func == FUNC_ENTRY) &&
                ({1'b0, in_entry_index} < 9'(PALETTE_DEPTH));
    pal_waddr = PAL_AW'(in_entry_index);
    pal_wdata = in_entry_color;
    job_push  = emit;
    job.word   = in_plane_word;
    job.planes = eff_p;
    job.base   = planar_r ? 12'(g_cur) : 12'd0;
    job.stride = planar_r ? 12'(ngroups) : 12'd1;
    job.valid  = planar_r || ilv_ok;
    job.colors = eff_c;
    job.x0     = x0_full[11:0];
    job.npix   = (rem > 13'd16) ? 5'd16 : rem[4:0];
    job.y      = r_cur[9:0];
    job.fdone  = (g_cur + 9'd1 == ngroups) && (r_cur + 11'd1 == eff_h);
  end

  // counter advance
  always_comb begin
    plane_nxt = p_cur;
    group_nxt = g_cur;
    row_nxt   = r_cur;
    if (planar_r) begin
      group_nxt = g_cur + 9'd1;
      if (group_nxt >= ngroups) begin
        group_nxt = 9'd0;
        plane_nxt = p_cur + 4'd1;
        if (plane_nxt >= eff_p) begin
          plane_nxt = 4'd0;
          row_nxt = (r_cur + 11'd1 >= eff_h) ? 11'd0 : r_cur + 11'd1;
        end
      end
    end else begin
      plane_nxt = p_cur + 4'd1;
      if (plane_nxt >= eff_p) begin
        plane_nxt = 4'd0;
        group_nxt = g_cur + 9'd1;
        if (group_nxt >= ngroups) begin
          group_nxt = 9'd0;
          row_nxt = (r_cur + 11'd1 >= eff_h) ? 11'd0 : r_cur + 11'd1;
        end
      end
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd320;
      height_r <= 11'd200;
      bpp_r    <= 4'd4;
      colors_r <= 9'd0;
      planar_r <= 1'b0;
      plane_r  <= 4'd0;
      group_r  <= 9'd0;
      row_r    <= 11'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_BPP:    bpp_r    <= cfg_data[3:0];
        REG_COLORS: colors_r <= cfg_data[8:0];
        REG_PLANAR: planar_r <= cfg_data[0];
        default: ;
      endcase
      if (cfg_index <= REG_PLANAR) begin
        plane_r <= 4'd0;
        group_r <= 9'd0;
        row_r   <= 11'd0;
      end
    end else if (accept && in_func == FUNC_WORD) begin
      plane_r <= plane_nxt;
      group_r <= group_nxt;
      row_r   <= row_nxt;
    end
  end

  // plane counter stays in range after a word
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_WORD && !cfg_we) |=> (plane_r < 4'(MAX_PLANES)))
    else $error("plane counter out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (job.npix != 5'd0 && job.npix <= 5'd16))
    else $error("empty group job");
  assert property (@(posedge clk) disable iff (!rst_n)
    !(rs_we && job_push))
    else $error("word both stored and issued");
  assert property (@(posedge clk) disable iff (!rst_n)
    !(rs_we && rs_busy))
    else $error("row store written under a pending gather");

endmodule

// ===== rtl/core/btip_back.sv =====
// ----------------------------------------------------------------------------
// btip_back: job queue and pixel emitter
// Gathers plane words one per cycle, then sends pixels through the palette
// memory into a two-entry output queue.
// ----------------------------------------------------------------------------
module btip_back #(
  parameter int MAX_PLANES    = btip_pkg::MaxPlanesDef,
  parameter int RS_AW         = 4,
  parameter int PAL_AW        = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_push,
  input  btip_pkg::job_t     job,
  output logic               job_full,
  output logic               rs_busy,
  output logic               pal_busy,
  output logic [RS_AW-1:0]   rs_raddr,
  input  logic [15:0]        rs_rdata,
  output logic [PAL_AW-1:0]  pal_raddr,
  input  logic [31:0]        pal_rdata,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [31:0]        out_pixel_color,
  output logic [9:0]         out_pixel_x,
  output logic [9:0]         out_pixel_y,
  output logic               out_run_last,
  output logic               out_frame_done
);
  import btip_pkg::*;

  localparam int PwAw = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_WAIT = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  typedef struct packed {
    logic [31:0] color;
    logic [9:0]  x;
    logic [9:0]  y;
    logic        last;
    logic        fdone;
  } pix_t;

  // two-entry job queue
  job_t        jq_r [2];
  logic        jq_wp_r, jq_rp_r;
  logic [1:0]  jq_cnt_r;
  job_t        cur_r;
  state_t      state_r, state_nxt;
  logic [3:0]  q_r;          // plane being read
  logic [3:0]  qd_r;         // plane whose data arrives
  logic        rd_pend_r;
  logic [15:0] pw_r [MAX_PLANES];
  logic [4:0]  k_r;
  logic        issue;
  logic [7:0]  idx;
  logic [8:0]  idx_c;
  // palette read pipeline
  logic        pv_r;
  logic [9:0]  px_r, py_r;
  logic        pl_r, pf_r;
  // output queue
  pix_t        oq_r [2];
  logic        oq_wp_r, oq_rp_r;
  logic [1:0]  oq_cnt_r;
  logic        opop;
  logic        take_job;

  assign job_full = (jq_cnt_r == 2'd2);
  // row store still needed by a queued or loading job
  assign rs_busy  = (jq_cnt_r != 2'd0) || (state_r == S_LOAD);
  // palette still needed by some pixel
  assign pal_busy = (jq_cnt_r != 2'd0) || (state_r != S_IDLE);
  assign take_job = (state_r == S_IDLE) && (jq_cnt_r != 2'd0);
  assign rs_raddr = RS_AW'(cur_r.base + 12'(q_r) * cur_r.stride);
  // room for a pixel in flight plus the new one
  assign issue = (state_r == S_EMIT) &&
                 ({1'b0, oq_cnt_r} + {2'd0, pv_r} < 3'd2);
  assign opop = out_pop && !out_empty;

  // index of pixel k
  always_comb begin
    idx = 8'd0;
    for (int q = 0; q < MAX_PLANES; q++) begin
      if (4'(q) < cur_r.planes) begin
        idx[q] = (4'(q) + 4'd1 == cur_r.planes) ? cur_r.word[4'(LastBit) - k_r[3:0]]
                                                : pw_r[q][4'(LastBit) - k_r[3:0]];
      end
    end
    if (!cur_r.valid) idx = 8'd0;
    idx_c = ({1'b0, idx} >= cur_r.colors) ? cur_r.colors - 9'd1 : {1'b0, idx};
  end
  assign pal_raddr = PAL_AW'(idx_c);

  // control state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (take_job) state_nxt = S_LOAD;
      S_LOAD: if (q_r + 4'd1 >= cur_r.planes) state_nxt = S_WAIT;
      S_WAIT: state_nxt = S_EMIT;
      S_EMIT: if (issue && k_r + 5'd1 == cur_r.npix) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      jq_wp_r   <= 1'b0;
      jq_rp_r   <= 1'b0;
      jq_cnt_r  <= 2'd0;
      oq_wp_r   <= 1'b0;
      oq_rp_r   <= 1'b0;
      oq_cnt_r  <= 2'd0;
      pv_r      <= 1'b0;
      rd_pend_r <= 1'b0;
      q_r       <= 4'd0;
      k_r       <= 5'd0;
    end else begin
      state_r <= state_nxt;
      // job queue
      if (job_push) begin
        jq_r[jq_wp_r] <= job;
        jq_wp_r <= ~jq_wp_r;
      end
      if (take_job) begin
        cur_r   <= jq_r[jq_rp_r];
        jq_rp_r <= ~jq_rp_r;
        q_r     <= 4'd0;
        k_r     <= 5'd0;
      end
      jq_cnt_r <= jq_cnt_r + {1'b0, job_push} - {1'b0, take_job};
      // plane gather, data arrives in the cycle after its address
      rd_pend_r <= (state_r == S_LOAD);
      qd_r      <= q_r;
      if (state_r == S_LOAD) q_r <= q_r + 4'd1;
      if (rd_pend_r) pw_r[qd_r[PwAw-1:0]] <= rs_rdata;
      // pixel issue
      pv_r <= issue;
      if (issue) begin
        px_r <= 10'(cur_r.x0 + 12'(k_r));
        py_r <= cur_r.y;
        pl_r <= (k_r + 5'd1 == cur_r.npix);
        pf_r <= (k_r + 5'd1 == cur_r.npix) && cur_r.fdone;
        k_r  <= k_r + 5'd1;
      end
      // output queue
      if (pv_r) begin
        oq_r[oq_wp_r] <= '{color: pal_rdata, x: px_r, y: py_r, last: pl_r, fdone: pf_r};
        oq_wp_r <= ~oq_wp_r;
      end
      if (opop) oq_rp_r <= ~oq_rp_r;
      oq_cnt_r <= oq_cnt_r + {1'b0, pv_r} - {1'b0, opop};
    end
  end

  assign out_empty       = (oq_cnt_r == 2'd0);
  assign out_pixel_color = oq_r[oq_rp_r].color;
  assign out_pixel_x     = oq_r[oq_rp_r].x;
  assign out_pixel_y     = oq_r[oq_rp_r].y;
  assign out_run_last    = oq_r[oq_rp_r].last;
  assign out_frame_done  = oq_r[oq_rp_r].fdone;

  // queues never overflow and no pixel goes past its group end
  assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= 2'd2) else $error("output queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    jq_cnt_r <= 2'd2) else $error("job queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (k_r < cur_r.npix)) else $error("pixel past group end");
endmodule

// ===== rtl/core/bitplane_to_indexed_pixels.sv =====
// ----------------------------------------------------------------------------
// bitplane_to_indexed_pixels: bitplane words to palette colored pixels
// channel | dir | handshake        | payload
// input   | in  | in_push/in_full  | func, plane_word, entry_index, color
// result  | out | out_pop/out_empty| color, x, y, run_last, frame_done
// config  | in  | cfg_we           | cfg_index, cfg_data
// A group word first gathers its stored plane words from the row store, then its
// pixels leave through the palette memory while the output queue has room.
// Stored plane words wait while a job is queued or loading, palette writes until
// the emitter is idle with no job queued, group words while the job queue is full.
// Reset is synchronous; memories hold no reset state.
// A stalled out_pop stalls emission and then the input.
// ----------------------------------------------------------------------------
module bitplane_to_indexed_pixels #(
  parameter int MAX_WIDTH     = btip_pkg::MaxWidthDef,
  parameter int MAX_PLANES    = btip_pkg::MaxPlanesDef,
  parameter int PALETTE_DEPTH = btip_pkg::PaletteDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_func,
  input  logic [15:0] in_plane_word,
  input  logic [7:0]  in_entry_index,
  input  logic [31:0] in_entry_color,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_pixel_color,
  output logic [9:0]  out_pixel_x,
  output logic [9:0]  out_pixel_y,
  output logic        out_run_last,
  output logic        out_frame_done
);
  import btip_pkg::*;

  localparam int RsDepth = (MAX_PLANES - 1) * ((MAX_WIDTH + 15) / 16) + 1;
  localparam int RsAw    = (RsDepth > 1) ? $clog2(RsDepth) : 1;
  localparam int PalAw   = $clog2(PALETTE_DEPTH);

  logic             rs_we, pal_we, job_push, job_full;
  logic             rs_busy, pal_busy;
  logic [RsAw-1:0]  rs_waddr, rs_raddr;
  logic [15:0]      rs_wdata, rs_rdata;
  logic [PalAw-1:0] pal_waddr, pal_raddr;
  logic [31:0]      pal_wdata, pal_rdata;
  job_t             job;

  btip_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_PLANES(MAX_PLANES),
               .PALETTE_DEPTH(PALETTE_DEPTH)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_push, .in_full,
    .in_func, .in_plane_word, .in_entry_index, .in_entry_color,
    .rs_we, .rs_waddr, .rs_wdata, .pal_we, .pal_waddr, .pal_wdata,
    .job_push, .job, .job_full, .rs_busy, .pal_busy
  );

  btip_ram #(.WIDTH(16), .DEPTH(RsDepth)) u_rowstore (
    .clk, .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .raddr(rs_raddr), .rdata(rs_rdata)
  );

  btip_ram #(.WIDTH(32), .DEPTH(PALETTE_DEPTH)) u_palette (
    .clk, .we(pal_we), .waddr(pal_waddr), .wdata(pal_wdata),
    .raddr(pal_raddr), .rdata(pal_rdata)
  );

  btip_back #(.MAX_PLANES(MAX_PLANES), .RS_AW(RsAw), .PAL_AW(PalAw)) u_back (
    .clk, .rst_n, .job_push, .job, .job_full, .rs_busy, .pal_busy,
    .rs_raddr, .rs_rdata,
    .pal_raddr, .pal_rdata, .out_empty, .out_pop, .out_pixel_color,
    .out_pixel_x, .out_pixel_y, .out_run_last, .out_frame_done
  );

endmodule
